// ===== rtl/u2cal_pkg.sv =====
// Shared types, constants and calendar helpers for the seconds-to-calendar block.
// No dependencies; every module in rtl/ uses it by scoped names.
package u2cal_pkg;

	localparam int unsigned QueueDepth = 2;

	// reciprocals and divisors for the split; the low bits are stripped first
	// (86400 = 675 << 7, 3600 = 225 << 4, 60 = 15 << 2)
	localparam logic [24:0] DayRecip    = 25'd25451658;
	localparam logic [24:0] DayDivisor  = 25'd675;
	localparam logic [12:0] HourRecip   = 13'd4660;
	localparam logic [12:0] HourDivisor = 13'd225;
	localparam logic [12:0] MinRecip    = 13'd4369;
	localparam logic [9:0]  MinDivisor  = 10'd15;
	localparam logic [16:0] WeekRecip   = 17'd74898;

	localparam logic [16:0] WeekLen      = 17'd7;
	localparam logic [16:0] EpochWeekday = 17'd3;

	localparam logic [8:0] DaysInYear     = 9'd365;
	localparam logic [8:0] DaysInLeapYear = 9'd366;

	// year index counts from 1970
	localparam logic [1:0] LeapPhase  = 2'd2;
	localparam logic [7:0] Year2100   = 8'd130;
	localparam logic [7:0] YearBias   = 8'd226;
	localparam logic [7:0] LastYear   = 8'd136;
	localparam logic [3:0] LastMonth  = 4'd11;
	localparam logic [3:0] February   = 4'd1;

	typedef struct packed {
		logic [15:0] days;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [2:0]  weekday;
	} job_t;

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;
	typedef enum logic [1:0] {DIV_DAY, DIV_HOUR, DIV_MIN} div_phase_t;
	typedef enum logic [1:0] {B_IDLE, B_YEAR, B_MONTH, B_WRITE} back_state_t;

	function automatic logic leap_year(input logic [7:0] year_idx);
		return (year_idx[1:0] == LeapPhase) && (year_idx != Year2100);
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		unique case (month)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
			4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
			February:                                  len = leap ? 5'd29 : 5'd28;
			default:                                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ===== rtl/u2cal_stamp_if.sv =====
// Input channel: valid/ready handshake carrying a 32-bit seconds count.
// Standalone; used by u2cal_front and the top level.
interface u2cal_stamp_if;
	logic        valid;
	logic        ready;
	logic [31:0] unix_time;

	modport source(output valid, output unix_time, input ready);
	modport sink(input valid, input unix_time, output ready);
endinterface

// ===== rtl/u2cal_date_if.sv =====
// Output channel: valid/ready handshake carrying the calendar fields.
// Standalone; used by u2cal_back and the top level.
interface u2cal_date_if;
	logic       valid;
	logic       ready;
	logic [5:0] second_of_minute;
	logic [5:0] minute_of_hour;
	logic [4:0] hour_of_day;
	logic [2:0] weekday;
	logic [7:0] year_offset;
	logic [3:0] month_of_year;
	logic [4:0] day_of_month;

	modport source(output valid, output second_of_minute, output minute_of_hour,
		output hour_of_day, output weekday, output year_offset, output month_of_year,
		output day_of_month, input ready);
	modport sink(input valid, input second_of_minute, input minute_of_hour,
		input hour_of_day, input weekday, input year_offset, input month_of_year,
		input day_of_month, output ready);
endinterface

// ===== rtl/u2cal_front.sv =====
// Front end: accepts a seconds word and splits it by reciprocal multiplication with one
// correction step (by 86400, 3600, 60, and 7 for the weekday). Uses u2cal_pkg.
module u2cal_front (
	input  logic               clk,
	input  logic               arst_n,
	u2cal_stamp_if.sink        stamp,
	input  logic               q_full,
	output logic               q_push,
	output u2cal_pkg::job_t    q_job
);

	u2cal_pkg::front_state_t state_q, state_d;
	u2cal_pkg::div_phase_t   phase_q;
	logic        fix_q;
	logic [31:0] stamp_q;
	logic [16:0] rem_q;
	logic [15:0] qe_q;
	logic [12:0] wqe_q;
	logic [15:0] days_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;
	logic [5:0]  sec_q;
	logic [2:0]  wday_q;

	logic [24:0] day_x;
	logic [49:0] day_prod;
	logic [10:0] day_sub;
	logic        day_carry;
	logic [9:0]  day_rem;
	logic [12:0] hour_y;
	logic [24:0] hour_prod;
	logic [8:0]  hour_sub;
	logic        hour_carry;
	logic [7:0]  hour_rem;
	logic [9:0]  min_z;
	logic [21:0] min_prod;
	logic [4:0]  min_sub;
	logic        min_carry;
	logic [3:0]  min_rem;
	logic [16:0] week_w;
	logic [31:0] week_prod;
	logic [3:0]  week_sub;
	logic        week_carry;
	logic [2:0]  week_rem;
	logic        accept;

	assign day_x     = stamp_q[31:7];
	assign day_prod  = 50'(day_x) * 50'(u2cal_pkg::DayRecip);
	assign day_sub   = 11'(day_x - 25'(qe_q) * u2cal_pkg::DayDivisor);
	assign day_carry = {14'd0, day_sub} >= u2cal_pkg::DayDivisor;
	assign day_rem   = day_carry ? 10'({14'd0, day_sub} - u2cal_pkg::DayDivisor)
		: day_sub[9:0];

	assign hour_y     = rem_q[16:4];
	assign hour_prod  = 25'(hour_y) * 25'(u2cal_pkg::HourRecip);
	assign hour_sub   = 9'(hour_y - 13'(qe_q[4:0]) * u2cal_pkg::HourDivisor);
	assign hour_carry = {4'd0, hour_sub} >= u2cal_pkg::HourDivisor;
	assign hour_rem   = hour_carry ? 8'({4'd0, hour_sub} - u2cal_pkg::HourDivisor)
		: hour_sub[7:0];

	assign min_z     = rem_q[11:2];
	assign min_prod  = 22'(min_z) * 22'(u2cal_pkg::MinRecip);
	assign min_sub   = 5'(min_z - 10'(qe_q[5:0]) * u2cal_pkg::MinDivisor);
	assign min_carry = {5'd0, min_sub} >= u2cal_pkg::MinDivisor;
	assign min_rem   = min_carry ? 4'({5'd0, min_sub} - u2cal_pkg::MinDivisor)
		: min_sub[3:0];

	assign week_w     = {1'b0, days_q} + u2cal_pkg::EpochWeekday;
	assign week_prod  = 32'(week_w) * 32'(u2cal_pkg::WeekRecip);
	assign week_sub   = 4'(week_w - 17'(wqe_q) * u2cal_pkg::WeekLen);
	assign week_carry = {13'd0, week_sub} >= u2cal_pkg::WeekLen;
	assign week_rem   = week_carry ? 3'({13'd0, week_sub} - u2cal_pkg::WeekLen)
		: week_sub[2:0];

	assign accept = stamp.valid && stamp.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			u2cal_pkg::F_IDLE: if (stamp.valid) state_d = u2cal_pkg::F_DIV;
			u2cal_pkg::F_DIV:  if (fix_q && phase_q == u2cal_pkg::DIV_MIN) state_d = u2cal_pkg::F_PUSH;
			u2cal_pkg::F_PUSH: if (!q_full) state_d = u2cal_pkg::F_IDLE;
			default:           state_d = u2cal_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		stamp.ready = state_q == u2cal_pkg::F_IDLE;
		q_push      = (state_q == u2cal_pkg::F_PUSH) && !q_full;
		q_job       = '{days: days_q, hour: hour_q, minute: min_q, second: sec_q, weekday: wday_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u2cal_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// each phase: estimate the quotient, then correct it by at most one
	always_ff @(posedge clk) begin
		if (accept) begin
			stamp_q <= stamp.unix_time;
			phase_q <= u2cal_pkg::DIV_DAY;
			fix_q   <= 1'b0;
		end else if (state_q == u2cal_pkg::F_DIV) begin
			fix_q <= !fix_q;
			unique case (phase_q)
				u2cal_pkg::DIV_DAY: begin
					if (!fix_q) begin
						qe_q <= day_prod[49:34];
					end else begin
						days_q  <= qe_q + {15'd0, day_carry};
						rem_q   <= {day_rem, stamp_q[6:0]};
						phase_q <= u2cal_pkg::DIV_HOUR;
					end
				end
				u2cal_pkg::DIV_HOUR: begin
					if (!fix_q) begin
						qe_q  <= {11'd0, hour_prod[24:20]};
						wqe_q <= week_prod[31:19];
					end else begin
						hour_q  <= qe_q[4:0] + {4'd0, hour_carry};
						wday_q  <= week_rem + 3'd1;
						rem_q   <= {5'd0, hour_rem, rem_q[3:0]};
						phase_q <= u2cal_pkg::DIV_MIN;
					end
				end
				u2cal_pkg::DIV_MIN: begin
					if (!fix_q) begin
						qe_q <= {10'd0, min_prod[21:16]};
					end else begin
						min_q <= qe_q[5:0] + {5'd0, min_carry};
						sec_q <= {min_rem, rem_q[1:0]};
					end
				end
				default: ;
			endcase
		end
	end

	a_fields_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == u2cal_pkg::F_PUSH) |-> (hour_q < 5'd24 && min_q < 6'd60
		&& sec_q < 6'd60 && wday_q != 3'd0))
		else $error("split fields out of range");

	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> (state_q == u2cal_pkg::F_IDLE))
		else $error("front not idle after push");

endmodule

// ===== rtl/u2cal_fifo.sv =====
// Short queue of split jobs between front and back end.
// Uses u2cal_pkg::job_t; depth set by the top level.
module u2cal_fifo #(
	parameter int unsigned Depth = u2cal_pkg::QueueDepth
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  u2cal_pkg::job_t din,
	input  logic            pop,
	output u2cal_pkg::job_t dout,
	output logic            full,
	output logic            empty
);

	localparam int unsigned PtrW = $clog2(Depth);
	localparam int unsigned CntW = $clog2(Depth + 1);

	u2cal_pkg::job_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = count_q == CntW'(Depth);
	assign empty = count_q == '0;
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= din;
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push |-> !full) and (pop |-> !empty))
		else $error("queue overrun or underrun");

endmodule

// ===== rtl/u2cal_back.sv =====
// Back end: walks whole years from 1970, then months of the found year,
// and holds the finished date word for the output channel. Uses u2cal_pkg.
module u2cal_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  u2cal_pkg::job_t q_job,
	output logic            q_pop,
	u2cal_date_if.source    date
);

	u2cal_pkg::back_state_t state_q, state_d;
	u2cal_pkg::job_t job_q;
	logic [15:0] days_q;
	logic [7:0]  yo_q;
	logic [3:0]  mon_q;
	logic        out_vld_q;
	logic [5:0]  res_sec_q;
	logic [5:0]  res_min_q;
	logic [4:0]  res_hour_q;
	logic [2:0]  res_wday_q;
	logic [7:0]  res_year_q;
	logic [3:0]  res_mon_q;
	logic [4:0]  res_day_q;

	logic       leap;
	logic [8:0] ylen;
	logic [4:0] mlen;
	logic       year_fits;
	logic       month_fits;
	logic       res_load;

	assign leap       = u2cal_pkg::leap_year(yo_q);
	assign ylen       = leap ? u2cal_pkg::DaysInLeapYear : u2cal_pkg::DaysInYear;
	assign mlen       = u2cal_pkg::month_days(mon_q, leap);
	assign year_fits  = days_q < {7'd0, ylen};
	assign month_fits = days_q < {11'd0, mlen};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			u2cal_pkg::B_IDLE:  if (!q_empty) state_d = u2cal_pkg::B_YEAR;
			u2cal_pkg::B_YEAR:  if (year_fits) state_d = u2cal_pkg::B_MONTH;
			u2cal_pkg::B_MONTH: begin
				if (month_fits || mon_q == u2cal_pkg::LastMonth) state_d = u2cal_pkg::B_WRITE;
			end
			u2cal_pkg::B_WRITE: if (!out_vld_q || date.ready) state_d = u2cal_pkg::B_IDLE;
			default:            state_d = u2cal_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (state_q == u2cal_pkg::B_IDLE) && !q_empty;
		res_load = (state_q == u2cal_pkg::B_WRITE) && (!out_vld_q || date.ready);
		date.valid            = out_vld_q;
		date.second_of_minute = res_sec_q;
		date.minute_of_hour   = res_min_q;
		date.hour_of_day      = res_hour_q;
		date.weekday          = res_wday_q;
		date.year_offset      = res_year_q;
		date.month_of_year    = res_mon_q;
		date.day_of_month     = res_day_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= u2cal_pkg::B_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load)        out_vld_q <= 1'b1;
			else if (date.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q  <= q_job;
			days_q <= q_job.days;
			yo_q   <= '0;
		end
		if (state_q == u2cal_pkg::B_YEAR) begin
			if (year_fits) begin
				mon_q <= '0;
			end else begin
				days_q <= days_q - {7'd0, ylen};
				yo_q   <= yo_q + 8'd1;
			end
		end
		if (state_q == u2cal_pkg::B_MONTH && !month_fits) begin
			days_q <= days_q - {11'd0, mlen};
			if (mon_q != u2cal_pkg::LastMonth) mon_q <= mon_q + 4'd1;
		end
		if (res_load) begin
			res_sec_q  <= job_q.second;
			res_min_q  <= job_q.minute;
			res_hour_q <= job_q.hour;
			res_wday_q <= job_q.weekday;
			res_year_q <= yo_q + u2cal_pkg::YearBias;
			res_mon_q  <= mon_q + 4'd1;
			res_day_q  <= days_q[4:0] + 5'd1;
		end
	end

	a_year_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == u2cal_pkg::B_YEAR) |-> (yo_q <= u2cal_pkg::LastYear))
		else $error("year walk ran past range");

	a_month_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == u2cal_pkg::B_MONTH) |-> (mon_q <= u2cal_pkg::LastMonth
		&& days_q < {7'd0, u2cal_pkg::DaysInLeapYear}))
		else $error("month walk state out of range");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> date.valid)
		else $error("result not presented after load");

endmodule

// ===== rtl/unix_seconds_to_calendar.sv =====
// Top level: seconds-since-1970 to calendar date and time.
// Depends on u2cal_pkg, u2cal_stamp_if, u2cal_date_if, u2cal_front, u2cal_fifo, u2cal_back.
//
//   port    dir   word
//   stamp   sink  unix_time[31:0]
//   date    src   second, minute, hour, weekday, year_offset, month, day
//
// Front, per word: accept, an estimate and a correct step each for day, hour and minute
// (weekday rides with the hour), then one push, which waits while the queue is full.
// Back, per word: a pop, the year walk, the month walk, then a write; the year walk sets the rate.
// Front and back overlap through the queue, so sustained rate is the slower of the two.
// arst_n clears control state only; datapath registers load with each word.
// A stalled date channel holds its word and backs up the queue, then the stamp channel.
module unix_seconds_to_calendar #(
	parameter int unsigned QueueDepth = u2cal_pkg::QueueDepth
) (
	input  logic         clk,
	input  logic         arst_n,
	u2cal_stamp_if.sink  stamp,
	u2cal_date_if.source date
);

	u2cal_pkg::job_t push_job;
	u2cal_pkg::job_t pop_job;
	logic            q_push;
	logic            q_pop;
	logic            q_full;
	logic            q_empty;

	u2cal_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.stamp  (stamp),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (push_job)
	);

	u2cal_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (push_job),
		.pop    (q_pop),
		.dout   (pop_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	u2cal_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_job   (pop_job),
		.q_pop   (q_pop),
		.date    (date)
	);

endmodule
